[rtl/atwa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atwa_pkg
// Shared types and constants of the affine transform window average block.
// ----------------------------------------------------------------------------
package atwa_pkg;

	localparam int NUM_LANES = 6;
	localparam int DATA_W    = 32;
	localparam int WL_W      = 7;

	localparam logic [WL_W-1:0] WINDOW_RESET = 7'd30;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_DIVLD,
		S_DIV,
		S_OUT
	} atwa_state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic clear;
		logic div_load;
		logic div_step;
	} atwa_lane_ctrl_t;

endpackage

[rtl/atwa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atwa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module atwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/atwa_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atwa_lane
// One matrix element: history RAM, running sum and a bit-serial rounding
// divider giving the signed mean of the held values.
// ----------------------------------------------------------------------------
module atwa_lane import atwa_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7,
	parameter int SW    = 39
) (
	input  logic              clk,
	input  logic              arst_n,
	input  atwa_lane_ctrl_t   ctrl,
	input  logic [AW-1:0]     rd_slot,
	input  logic [AW-1:0]     wr_slot,
	input  logic              replace,
	input  logic [CW-1:0]     den,
	input  logic [DATA_W-1:0] data_in,
	output logic [DATA_W-1:0] result
);

	logic [DATA_W-1:0] in_q;
	logic [DATA_W-1:0] old_data;
	logic [SW-1:0]     sum_q;
	logic [SW-1:0]     in_ext;
	logic [SW-1:0]     old_ext;
	logic [SW-1:0]     mag;
	logic [SW-1:0]     quo_q;
	logic [CW-1:0]     rem_q;
	logic              neg_q;
	logic [CW:0]       trial;
	logic              fits;

	atwa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (ctrl.update),
		.waddr (wr_slot),
		.wdata (in_q),
		.re    (ctrl.load),
		.raddr (rd_slot),
		.rdata (old_data)
	);

	assign in_ext  = {{(SW-DATA_W){in_q[DATA_W-1]}}, in_q};
	assign old_ext = replace ? {{(SW-DATA_W){old_data[DATA_W-1]}}, old_data} : '0;
	assign mag     = sum_q[SW-1] ? (SW'(0) - sum_q) : sum_q;

	// restoring divider, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SW-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			in_q <= data_in;
		end
		if (ctrl.div_load) begin
			quo_q <= mag + SW'(den >> 1);
			rem_q <= '0;
			neg_q <= sum_q[SW-1];
		end else if (ctrl.div_step) begin
			quo_q <= {quo_q[SW-2:0], fits};
			rem_q <= fits ? CW'(trial - {1'b0, den}) : trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctrl.clear) begin
			sum_q <= '0;
		end else if (ctrl.update) begin
			sum_q <= sum_q - old_ext + in_ext;
		end
	end

	assign result = neg_q ? (DATA_W'(0) - quo_q[DATA_W-1:0]) : quo_q[DATA_W-1:0];

endmodule

[rtl/affine_transform_window_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_window_average
// Element-wise rounded window mean of 2x3 affine estimates, six lanes wide.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall   | scale_xx .. offset_y, 6 x 32 bit
// out     | output    | out_valid / out_stall | avg_scale_xx .. avg_offset_y
// cfg     | input     | cfg_valid / cfg_ready | window_length, 7 bit
//
// A transaction runs through the update, divider load, divide and output
// states before the next accept, paced by the lanes' one-bit-a-cycle dividers.
// The result sits in an output register; the next input is taken while it
// waits, but the divider result is held until that register frees up.
// A pending window write holds the input off and is taken first.
// Reset loads window_length 30 and empties the history; no clearing pass.
// ----------------------------------------------------------------------------
module affine_transform_window_average import atwa_pkg::*; #(
	parameter int MAX_WINDOW = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [DATA_W-1:0] scale_xx,
	input  logic [DATA_W-1:0] skew_xy,
	input  logic [DATA_W-1:0] offset_x,
	input  logic [DATA_W-1:0] skew_yx,
	input  logic [DATA_W-1:0] scale_yy,
	input  logic [DATA_W-1:0] offset_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] avg_scale_xx,
	output logic [DATA_W-1:0] avg_skew_xy,
	output logic [DATA_W-1:0] avg_offset_x,
	output logic [DATA_W-1:0] avg_skew_yx,
	output logic [DATA_W-1:0] avg_scale_yy,
	output logic [DATA_W-1:0] avg_offset_y,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WL_W-1:0]   window_length
);

	localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW    = $clog2(MAX_WINDOW + 1);
	localparam int EW    = (CW > WL_W) ? CW : WL_W;
	localparam int SW    = DATA_W + CW;
	localparam int CNT_W = $clog2(SW + 1);

	atwa_state_t       state_q, state_d;
	atwa_lane_ctrl_t   ctrl;
	logic [WL_W-1:0]   wl_q;
	logic [CW-1:0]     filled_q;
	logic [AW-1:0]     oldest_q;
	logic [AW-1:0]     slot_q;
	logic              replace_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [EW-1:0]     wl_ext;
	logic [EW-1:0]     w_ext;
	logic [CW-1:0]     w_eff;
	logic              warm;
	logic [AW-1:0]     slot;
	logic [CW-1:0]     slot_next;
	logic              in_acc;
	logic              cfg_acc;
	logic              out_load;
	logic              out_valid_q;
	logic [DATA_W-1:0] lane_in  [NUM_LANES];
	logic [DATA_W-1:0] lane_res [NUM_LANES];
	logic [DATA_W-1:0] avg_q    [NUM_LANES];

	assign in_acc   = in_valid && !in_stall;
	assign cfg_acc  = cfg_valid && cfg_ready;
	assign in_stall = (state_q != S_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);

	// effective window: zero means one, capped at MAX_WINDOW
	assign wl_ext = EW'(wl_q);
	assign w_ext  = (wl_ext == '0) ? EW'(1) :
	                (wl_ext > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : wl_ext;
	assign w_eff  = w_ext[CW-1:0];

	assign warm = (filled_q < w_eff);
	always_comb begin
		if (warm) begin
			slot = filled_q[AW-1:0];
		end else if (CW'(oldest_q) < w_eff) begin
			slot = oldest_q;
		end else begin
			slot = '0;
		end
	end
	assign slot_next = CW'(slot) + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q     <= WINDOW_RESET;
			filled_q <= '0;
			oldest_q <= '0;
		end else if (cfg_acc) begin
			wl_q     <= window_length;
			filled_q <= '0;
			oldest_q <= '0;
		end else if (in_acc) begin
			if (warm) begin
				filled_q <= filled_q + CW'(1);
			end else begin
				oldest_q <= (slot_next >= w_eff) ? '0 : slot_next[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q    <= slot;
			replace_q <= !warm;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIVLD) begin
				cnt_q <= CNT_W'(SW);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d       = state_q;
		ctrl.load     = 1'b0;
		ctrl.update   = 1'b0;
		ctrl.clear    = cfg_acc;
		ctrl.div_load = 1'b0;
		ctrl.div_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && !cfg_acc) begin
					ctrl.load = 1'b1;
					state_d   = S_UPD;
				end
			end
			S_UPD: begin
				ctrl.update = 1'b1;
				state_d     = S_DIVLD;
			end
			S_DIVLD: begin
				ctrl.div_load = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign lane_in[0] = scale_xx;
	assign lane_in[1] = skew_xy;
	assign lane_in[2] = offset_x;
	assign lane_in[3] = skew_yx;
	assign lane_in[4] = scale_yy;
	assign lane_in[5] = offset_y;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		atwa_lane #(
			.DEPTH (MAX_WINDOW),
			.AW    (AW),
			.CW    (CW),
			.SW    (SW)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.rd_slot (slot),
			.wr_slot (slot_q),
			.replace (replace_q),
			.den     (filled_q),
			.data_in (lane_in[i]),
			.result  (lane_res[i])
		);
	end

	// merge: collect all lane results into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_q <= lane_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_scale_xx = avg_q[0];
	assign avg_skew_xy  = avg_q[1];
	assign avg_offset_x = avg_q[2];
	assign avg_skew_yx  = avg_q[3];
	assign avg_scale_yy = avg_q[4];
	assign avg_offset_y = avg_q[5];

endmodule
